// ===== hw/rtl/jaccard_distance_matrix_assert.svh =====
// ----------------------------------------------------------------------------
// jaccard distance matrix assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef JACCARD_DISTANCE_MATRIX_ASSERT_SVH
`define JACCARD_DISTANCE_MATRIX_ASSERT_SVH
`ifndef SYNTH
`define JDM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JDM_ASSERT(lbl, clk, rst, prop, msg)
`define JDM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/jdm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdm_pkg
// shared constants and types of the jaccard distance matrix block
// ----------------------------------------------------------------------------
package jdm_pkg;

   localparam int DEF_MAX_ROWS = 512;
   localparam int DEF_MAX_COLS = 64;

   localparam int SAMPLE_W    = 32;
   localparam int COLUMN_W    = 6;
   localparam int COL_COUNT_W = 7;
   localparam int ROW_COUNT_W = 10;
   localparam int CSR_DATA_W  = 10;
   localparam int FRAC_W      = 16;
   localparam int DIST_W      = FRAC_W + 1;
   localparam int STEP_CNT_W  = 5;

   localparam logic [COL_COUNT_W-1:0] RESET_COL_COUNT = 7'd64;
   localparam logic [ROW_COUNT_W-1:0] RESET_ROW_COUNT = 10'd512;

   localparam logic CSR_COL_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT = 1'b1;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] quotient;
   } div_result_type;

endpackage

// ===== hw/rtl/jdm_ram.sv =====
// ----------------------------------------------------------------------------
// jdm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module jdm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/jdm_loader.sv =====
// ----------------------------------------------------------------------------
// jdm_loader
// builds each row bit vector and writes it to the row memory per beat
// ----------------------------------------------------------------------------
module jdm_loader #(
   parameter int MAX_ROWS = jdm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = jdm_pkg::DEF_MAX_COLS,
   parameter int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [jdm_pkg::SAMPLE_W-1:0]  sample,
   input  logic [jdm_pkg::COL_COUNT_W-1:0]      cols_eff,
   input  logic [jdm_pkg::ROW_COUNT_W-1:0]      rows_eff,
   output logic                                 wr_en,
   output logic [ROW_AW-1:0]                    wr_addr,
   output logic [MAX_COLS-1:0]                  wr_data
);
   import jdm_pkg::*;

   logic [MAX_COLS-1:0]    acc_ff, acc_in;
   logic [COLUMN_W-1:0]    load_col_ff, load_col_in;
   logic [ROW_COUNT_W-1:0] load_row_ff, load_row_in;
   logic                   pos;
   logic [COL_COUNT_W-1:0] col_next;
   logic [ROW_COUNT_W-1:0] row_next;
   logic [31:0]            row_wide;

   assign pos      = (sample != '0) && !sample[SAMPLE_W-1];
   assign col_next = {1'b0, load_col_ff} + 7'd1;
   assign row_next = load_row_ff + 10'd1;
   assign row_wide = 32'(load_row_ff);

   always_comb begin
      for (int m = 0; m < MAX_COLS; m++) begin
         acc_in[m] = ((load_col_ff != '0) && acc_ff[m])
                   || (pos && (load_col_ff == COLUMN_W'(m)));
      end
   end

   always_comb begin
      load_col_in = load_col_ff;
      load_row_in = load_row_ff;
      if (load) begin
         if (col_next >= cols_eff) begin
            load_col_in = '0;
            load_row_in = (row_next >= rows_eff) ? '0 : row_next;
         end else begin
            load_col_in = col_next[COLUMN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         load_row_ff <= '0;
      end else begin
         load_col_ff <= load_col_in;
         load_row_ff <= load_row_in;
      end
      if (load) begin
         acc_ff <= acc_in;
      end
   end

   assign wr_en   = load && (row_wide < 32'(MAX_ROWS));
   assign wr_addr = row_wide[ROW_AW-1:0];
   assign wr_data = acc_in;

endmodule

// ===== hw/rtl/jdm_divider.sv =====
// ----------------------------------------------------------------------------
// jdm_divider
// restoring divider, one quotient bit per cycle, unsigned q1.16 ratio
// ----------------------------------------------------------------------------
`include "jaccard_distance_matrix_assert.svh"

module jdm_divider #(
   parameter int CNT_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CNT_W-1:0]        dividend,
   input  logic [CNT_W-1:0]        divisor,
   output jdm_pkg::div_result_type result
);
   import jdm_pkg::*;

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic [CNT_W:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]      den_ff;
   logic [DIST_W-1:0]     quo_ff, quo_in;
   logic [DIST_W-1:0]     q_ff;
   logic                  ge;
   logic [CNT_W:0]        rem_sub;

   assign ge      = rem_ff >= {1'b0, den_ff};
   assign rem_sub = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   assign quo_in  = {quo_ff[DIST_W-2:0], ge};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, dividend};
      end else if (run_ff) begin
         rem_in  = {rem_sub[CNT_W-1:0], 1'b0};
         step_in = step_ff + 5'd1;
         if (step_ff == STEP_CNT_W'(DIST_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= divisor;
         quo_ff <= '0;
      end else if (run_ff) begin
         quo_ff <= quo_in;
      end
      if (done_in) begin
         q_ff <= quo_in;
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = q_ff;

   `JDM_ASSERT(a_div_no_restart, clock, reset, start |-> !run_ff, "divider restarted while running")
   `JDM_ASSERT(a_div_done_after_run, clock, reset, done_ff |-> $past(run_ff) && !run_ff, "divider done without a run")

endmodule

// ===== hw/rtl/jaccard_distance_matrix.sv =====
// ----------------------------------------------------------------------------
// jaccard_distance_matrix
// jaccard distances between matrix columns from stored positive-bit rows
// ----------------------------------------------------------------------------
// load beat: written to the row ram at the accepting edge, busy stays low
// request: walk and drain states stream the row ram through per-column union and common
//    counters; diagonal and empty-union columns are emitted from the scan state, other
//    columns use the one-bit-per-cycle divider; busy is high for the whole request
// results are strobed for one cycle each, in column order; the receiver cannot stall
// synchronous active-high reset clears control and config; row ram contents are kept
// ----------------------------------------------------------------------------
`include "jaccard_distance_matrix_assert.svh"

module jaccard_distance_matrix #(
   parameter int MAX_ROWS = jdm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = jdm_pkg::DEF_MAX_COLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_kind,
   input  logic signed [jdm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [jdm_pkg::COLUMN_W-1:0]         req_column,
   output logic                                 rsp_valid,
   output logic [jdm_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                 rsp_empty_union,
   output logic [jdm_pkg::COLUMN_W-1:0]         rsp_first_col,
   output logic [jdm_pkg::COLUMN_W-1:0]         rsp_second_col,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [jdm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import jdm_pkg::*;

   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int CNT_W  = $clog2(MAX_ROWS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [COL_COUNT_W-1:0] col_count_ff;
   logic [ROW_COUNT_W-1:0] row_count_ff;
   logic [COL_COUNT_W-1:0] cols_eff;
   logic [ROW_COUNT_W-1:0] rows_eff;

   logic                   accept, load, request;
   logic [COLUMN_W-1:0]    j_ff;
   logic [ROW_COUNT_W-1:0] i_ff, i_in;
   logic [COL_COUNT_W-1:0] k_ff, k_in;
   logic                   pend_ff;
   logic [31:0]            i_wide;

   logic [CNT_W-1:0]       uni_ff [MAX_COLS];
   logic [CNT_W-1:0]       uni_in [MAX_COLS];
   logic [CNT_W-1:0]       com_ff [MAX_COLS];
   logic [CNT_W-1:0]       com_in [MAX_COLS];

   logic                   wr_en;
   logic [ROW_AW-1:0]      wr_addr;
   logic [MAX_COLS-1:0]    wr_data;
   logic                   rd_en;
   logic [ROW_AW-1:0]      rd_addr;
   logic [MAX_COLS-1:0]    rd_data;
   logic                   a_bit;

   logic                   diag, empty, is_last, emit, div_start;
   div_result_type         div_res;

   logic                   rsp_valid_ff;
   logic [DIST_W-1:0]      rsp_distance_ff;
   logic                   rsp_empty_union_ff;
   logic [COLUMN_W-1:0]    rsp_second_col_ff;
   logic                   rsp_last_ff;

   // config registers and effective counts
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= RESET_COL_COUNT;
         row_count_ff <= RESET_ROW_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COL_COUNT: col_count_ff <= csr_data[COL_COUNT_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_data[ROW_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (col_count_ff == '0) begin
         cols_eff = 7'd1;
      end else if (32'(col_count_ff) > MAX_COLS) begin
         cols_eff = COL_COUNT_W'(MAX_COLS);
      end else begin
         cols_eff = col_count_ff;
      end
      if (row_count_ff == '0) begin
         rows_eff = 10'd1;
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rows_eff = ROW_COUNT_W'(MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
   end

   // intake
   assign busy    = state_ff != ST_IDLE;
   assign accept  = start && !busy;
   assign load    = accept && (req_kind == KIND_LOAD);
   assign request = accept && (req_kind == KIND_REQUEST)
                 && ({1'b0, req_column} < cols_eff);

   jdm_loader #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .ROW_AW   (ROW_AW)
   ) u_loader (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .sample   (req_sample),
      .cols_eff (cols_eff),
      .rows_eff (rows_eff),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   assign i_wide  = 32'(i_ff);
   assign rd_en   = state_ff == ST_WALK;
   assign rd_addr = i_wide[ROW_AW-1:0];

   jdm_ram #(
      .WIDTH   (MAX_COLS),
      .DEPTH   (MAX_ROWS),
      .AW      (ROW_AW)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign a_bit = rd_data[j_ff[COL_W-1:0]];

   // column lanes, lane 0 always holds column k
   assign diag      = k_ff == {1'b0, j_ff};
   assign empty     = !diag && (uni_ff[0] == '0);
   assign is_last   = (k_ff + 7'd1) == cols_eff;
   assign div_start = (state_ff == ST_SCAN) && !diag && !empty;
   assign emit      = ((state_ff == ST_SCAN) && (diag || empty))
                   || ((state_ff == ST_DIV) && div_res.done);

   jdm_divider #(
      .CNT_W    (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (uni_ff[0] - com_ff[0]),
      .divisor  (uni_ff[0]),
      .result   (div_res)
   );

   always_comb begin
      uni_in = uni_ff;
      com_in = com_ff;
      if (request) begin
         for (int m = 0; m < MAX_COLS; m++) begin
            uni_in[m] = '0;
            com_in[m] = '0;
         end
      end else if (pend_ff) begin
         for (int m = 0; m < MAX_COLS; m++) begin
            uni_in[m] = uni_ff[m] + CNT_W'(a_bit | rd_data[m]);
            com_in[m] = com_ff[m] + CNT_W'(a_bit & rd_data[m]);
         end
      end else if (emit) begin
         for (int m = 0; m < MAX_COLS - 1; m++) begin
            uni_in[m] = uni_ff[m + 1];
            com_in[m] = com_ff[m + 1];
         end
         uni_in[MAX_COLS-1] = '0;
         com_in[MAX_COLS-1] = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (request) begin
               state_in = ST_WALK;
               i_in     = '0;
            end
         end
         ST_WALK: begin
            i_in = i_ff + 10'd1;
            if ((i_ff + 10'd1) == rows_eff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCAN;
            k_in     = '0;
         end
         ST_SCAN: begin
            if (emit) begin
               k_in     = k_ff + 7'd1;
               state_in = is_last ? ST_IDLE : ST_SCAN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (emit) begin
               k_in     = k_ff + 7'd1;
               state_in = is_last ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= rd_en;
         rsp_valid_ff <= emit;
      end
      i_ff   <= i_in;
      k_ff   <= k_in;
      uni_ff <= uni_in;
      com_ff <= com_in;
      if (request) begin
         j_ff <= req_column;
      end
      if (emit) begin
         rsp_distance_ff    <= (state_ff == ST_DIV) ? div_res.quotient : '0;
         rsp_empty_union_ff <= (state_ff == ST_SCAN) && empty;
         rsp_second_col_ff  <= k_ff[COLUMN_W-1:0];
         rsp_last_ff        <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_empty_union = rsp_empty_union_ff;
   assign rsp_first_col   = j_ff;
   assign rsp_second_col  = rsp_second_col_ff;
   assign rsp_last        = rsp_last_ff;

   `JDM_ASSERT(a_rsp_from_busy, clock, reset,
      rsp_valid_ff |-> $past(state_ff != ST_IDLE), "result beat without a running request")
   `JDM_ASSERT(a_last_ends_row, clock, reset,
      rsp_valid_ff && rsp_last_ff |-> state_ff == ST_IDLE,
      "request still running after last beat")
   `JDM_ASSERT(a_scan_in_range, clock, reset,
      state_ff == ST_SCAN |-> k_ff < cols_eff, "column index past column count")

endmodule

// ===== verif/jaccard_distance_matrix_checker.sv =====
// ----------------------------------------------------------------------------
// jaccard_distance_matrix_checker
// watches the item, result and register channels of the distance block,
// keeps its own copy of the row bit vectors, load position and register
// values, predicts every distance beat of an accepted request and compares
// each strobed result beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module jaccard_distance_matrix_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic                                 req_kind,
   input  logic signed [jdm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [jdm_pkg::COLUMN_W-1:0]         req_column,
   input  logic                                 rsp_valid,
   input  logic [jdm_pkg::DIST_W-1:0]           rsp_distance,
   input  logic                                 rsp_empty_union,
   input  logic [jdm_pkg::COLUMN_W-1:0]         rsp_first_col,
   input  logic [jdm_pkg::COLUMN_W-1:0]         rsp_second_col,
   input  logic                                 rsp_last,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [jdm_pkg::CSR_DATA_W-1:0]       csr_data,
   output int                                   failure_count,
   output int                                   pending_count,
   output int                                   beats_checked
);
   import jdm_pkg::*;

   typedef struct packed {
      logic [DIST_W-1:0]   distance;
      logic                empty_union;
      logic [COLUMN_W-1:0] first_col;
      logic [COLUMN_W-1:0] second_col;
      logic                last;
   } distance_beat_type;

   distance_beat_type         expected_beats [$];
   distance_beat_type         oldest_beat;
   logic [DEF_MAX_COLS-1:0]   row_bits [DEF_MAX_ROWS];
   logic [COL_COUNT_W-1:0]    col_count_reg;
   logic [ROW_COUNT_W-1:0]    row_count_reg;
   int unsigned               fill_row;
   int unsigned               fill_col;

   initial begin
      for (int r = 0; r < DEF_MAX_ROWS; r++) row_bits[r] = '0;
   end

   function automatic int unsigned active_cols();
      int unsigned c;
      c = col_count_reg;
      if (c == 0) c = 1;
      if (c > DEF_MAX_COLS) c = DEF_MAX_COLS;
      return c;
   endfunction

   function automatic int unsigned active_rows();
      int unsigned r;
      r = row_count_reg;
      if (r == 0) r = 1;
      if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (failure_count < 40)
         $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      failure_count++;
   endtask

   task automatic absorb_element(input logic signed [SAMPLE_W-1:0] value);
      int unsigned cols;
      int unsigned rows;
      cols = active_cols();
      rows = active_rows();
      if (fill_col == 0) row_bits[fill_row] = '0;
      if (value > 0) row_bits[fill_row][fill_col] = 1'b1;
      fill_col++;
      if (fill_col >= cols) begin
         fill_col = 0;
         fill_row++;
         if (fill_row >= rows) fill_row = 0;
      end
   endtask

   task automatic predict_distance_row(input int unsigned j);
      int unsigned       cols;
      int unsigned       rows;
      int unsigned       union_rows;
      int unsigned       common_rows;
      distance_beat_type beat;
      cols = active_cols();
      rows = active_rows();
      if (j < cols) begin
         for (int unsigned k = 0; k < cols; k++) begin
            beat.distance    = '0;
            beat.empty_union = 1'b0;
            if (k != j) begin
               union_rows  = 0;
               common_rows = 0;
               for (int unsigned i = 0; i < rows; i++) begin
                  union_rows  += row_bits[i][j] | row_bits[i][k];
                  common_rows += row_bits[i][j] & row_bits[i][k];
               end
               if (union_rows == 0)
                  beat.empty_union = 1'b1;
               else
                  beat.distance = DIST_W'(((union_rows - common_rows) << FRAC_W) / union_rows);
            end
            beat.first_col  = COLUMN_W'(j);
            beat.second_col = COLUMN_W'(k);
            beat.last       = (k + 1 == cols);
            expected_beats.push_back(beat);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         col_count_reg = RESET_COL_COUNT;
         row_count_reg = RESET_ROW_COUNT;
         fill_row      = 0;
         fill_col      = 0;
         failure_count = 0;
         beats_checked = 0;
         expected_beats.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("result beat with none expected, second_col",
                               rsp_second_col, 0);
            end else begin
               oldest_beat = expected_beats.pop_front();
               beats_checked++;
               if (rsp_distance !== oldest_beat.distance)
                  report_mismatch("distance", rsp_distance, oldest_beat.distance);
               if (rsp_empty_union !== oldest_beat.empty_union)
                  report_mismatch("empty_union", rsp_empty_union, oldest_beat.empty_union);
               if (rsp_first_col !== oldest_beat.first_col)
                  report_mismatch("first_col", rsp_first_col, oldest_beat.first_col);
               if (rsp_second_col !== oldest_beat.second_col)
                  report_mismatch("second_col", rsp_second_col, oldest_beat.second_col);
               if (rsp_last !== oldest_beat.last)
                  report_mismatch("last", rsp_last, oldest_beat.last);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COL_COUNT)
               col_count_reg = csr_data[COL_COUNT_W-1:0];
            else
               row_count_reg = csr_data[ROW_COUNT_W-1:0];
         end
         if (start && !busy) begin
            if (req_kind == KIND_LOAD)
               absorb_element(req_sample);
            else
               predict_distance_row(req_column);
         end
      end
      pending_count <= expected_beats.size();
   end

endmodule

// ===== verif/jaccard_distance_matrix_test.sv =====
// ----------------------------------------------------------------------------
// jaccard_distance_matrix_test
// drives element loads and distance requests into the block under several
// column and row count settings, from a small hand-built matrix through a
// tall one-column and a full-width one-row matrix to random small matrices,
// with random sender gaps; the checker beside the block predicts and
// compares every result beat
// ----------------------------------------------------------------------------
module jaccard_distance_matrix_test;
   import jdm_pkg::*;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_kind;
   logic signed [SAMPLE_W-1:0]   req_sample;
   logic [COLUMN_W-1:0]          req_column;
   logic                         rsp_valid;
   logic [DIST_W-1:0]            rsp_distance;
   logic                         rsp_empty_union;
   logic [COLUMN_W-1:0]          rsp_first_col;
   logic [COLUMN_W-1:0]          rsp_second_col;
   logic                         rsp_last;
   logic                         csr_valid;
   logic                         csr_ready;
   logic                         csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   int                           failure_count;
   int                           pending_count;
   int                           beats_checked;

   int unsigned                  cur_cols;
   int unsigned                  cur_rows;
   int unsigned                  pos_row;
   int unsigned                  pos_col;
   bit                           row_written [DEF_MAX_ROWS];
   int                           max_gap;
   int                           loads_sent;
   int                           requests_sent;
   int                           ignored_sent;
   int                           random_items;

   jaccard_distance_matrix dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_sample      (req_sample),
      .req_column      (req_column),
      .rsp_valid       (rsp_valid),
      .rsp_distance    (rsp_distance),
      .rsp_empty_union (rsp_empty_union),
      .rsp_first_col   (rsp_first_col),
      .rsp_second_col  (rsp_second_col),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   jaccard_distance_matrix_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_sample      (req_sample),
      .req_column      (req_column),
      .rsp_valid       (rsp_valid),
      .rsp_distance    (rsp_distance),
      .rsp_empty_union (rsp_empty_union),
      .rsp_first_col   (rsp_first_col),
      .rsp_second_col  (rsp_second_col),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failure_count   (failure_count),
      .pending_count   (pending_count),
      .beats_checked   (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL jaccard_distance_matrix");
      $finish;
   end

   function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit rows_ready();
      for (int unsigned r = 0; r < cur_rows; r++)
         if (!row_written[r]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'h0000_0001;
         4: return 32'hFFFF_FFFF;
         5, 6: return $urandom() & 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // one beat on the item channel; start stays high into the next beat when no gap
   task automatic drive_item(input logic kind, input logic [SAMPLE_W-1:0] sample,
                             input logic [COLUMN_W-1:0] column);
      int gap;
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start      = 1'b1;
      req_kind   = kind;
      req_sample = sample;
      req_column = column;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (kind == KIND_LOAD) begin
         loads_sent++;
         if (pos_col == 0) row_written[pos_row] = 1'b1;
         pos_col++;
         if (pos_col >= cur_cols) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= cur_rows) pos_row = 0;
         end
      end else if (column >= cur_cols) begin
         ignored_sent++;
      end else begin
         requests_sent++;
      end
   endtask

   task automatic send_load();
      drive_item(KIND_LOAD, pick_sample(), COLUMN_W'($urandom()));
   endtask

   task automatic send_request(input logic [COLUMN_W-1:0] column);
      drive_item(KIND_REQUEST, $urandom(), column);
   endtask

   task automatic pick_request();
      if (cur_cols < DEF_MAX_COLS && $urandom_range(0, 5) == 0)
         send_request(COLUMN_W'($urandom_range(cur_cols, DEF_MAX_COLS - 1)));
      else
         send_request(COLUMN_W'($urandom_range(0, cur_cols - 1)));
   endtask

   task automatic write_reg(input logic index, input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (index == CSR_COL_COUNT)
         cur_cols = clamp_count(data[COL_COUNT_W-1:0], DEF_MAX_COLS);
      else
         cur_rows = clamp_count(data[ROW_COUNT_W-1:0], DEF_MAX_ROWS);
   endtask

   // wait until every predicted beat has arrived and the block is quiet
   task automatic settle();
      start = 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   initial begin
      int unsigned n;
      reset      = 1'b1;
      start      = 1'b0;
      req_kind   = KIND_LOAD;
      req_sample = '0;
      req_column = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_COL_COUNT;
      csr_data   = '0;
      cur_cols   = RESET_COL_COUNT;
      cur_rows   = RESET_ROW_COUNT;
      pos_row    = 0;
      pos_col    = 0;
      max_gap    = 13;
      loads_sent    = 0;
      requests_sent = 0;
      ignored_sent  = 0;
      random_items  = 0;
      for (int r = 0; r < DEF_MAX_ROWS; r++) row_written[r] = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // hand-built 4x2 matrix: columns 0 and 1 identical, columns 2 and 3 empty
      write_reg(CSR_COL_COUNT, 10'd4);
      write_reg(CSR_ROW_COUNT, 10'd2);
      drive_item(KIND_LOAD, 32'h0000_0001, 6'd0);
      drive_item(KIND_LOAD, 32'h7FFF_FFFF, 6'd63);
      drive_item(KIND_LOAD, 32'h0000_0000, 6'd0);
      drive_item(KIND_LOAD, 32'h8000_0000, 6'd63);
      drive_item(KIND_LOAD, 32'h7FFF_FFFF, 6'd0);
      drive_item(KIND_LOAD, 32'h0000_0001, 6'd63);
      drive_item(KIND_LOAD, 32'hFFFF_FFFF, 6'd0);
      drive_item(KIND_LOAD, 32'h0000_0000, 6'd63);
      send_request(6'd0);
      send_request(6'd1);
      send_request(6'd2);
      send_request(6'd3);
      send_request(6'd4);
      send_request(6'd63);
      settle();

      // zero counts act as one column and one row
      write_reg(CSR_COL_COUNT, 10'd0);
      write_reg(CSR_ROW_COUNT, 10'd0);
      send_request(6'd0);
      send_request(6'd1);
      drive_item(KIND_LOAD, 32'h0000_0001, 6'd21);
      send_request(6'd0);
      settle();

      // tall matrix, one column wide
      write_reg(CSR_COL_COUNT, 10'd1);
      write_reg(CSR_ROW_COUNT, 10'd32);
      repeat (32) send_load();
      send_request(6'd0);
      send_request(COLUMN_W'($urandom_range(1, DEF_MAX_COLS - 1)));
      settle();

      // column count above range acts as the maximum, one row
      write_reg(CSR_ROW_COUNT, 10'd1);
      write_reg(CSR_COL_COUNT, 10'h3FF);
      repeat (DEF_MAX_COLS) send_load();
      send_request(6'd63);
      send_request(COLUMN_W'($urandom()));
      settle();

      // row count above range acts as the maximum while loading
      write_reg(CSR_COL_COUNT, 10'd1);
      write_reg(CSR_ROW_COUNT, 10'h3FF);
      repeat (4) send_load();
      settle();
      write_reg(CSR_ROW_COUNT, 10'd8);
      send_request(6'd0);
      settle();

      while (random_items < 30) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0: write_reg(CSR_COL_COUNT, CSR_DATA_W'($urandom()));
               1: write_reg(CSR_COL_COUNT, 10'd64);
               default: write_reg(CSR_COL_COUNT, CSR_DATA_W'($urandom_range(1, 8)));
            endcase
            write_reg(CSR_ROW_COUNT, ($urandom_range(0, 7) == 0) ?
                      CSR_DATA_W'($urandom()) : CSR_DATA_W'($urandom_range(1, 8)));
         end else begin
            write_reg(CSR_ROW_COUNT, ($urandom_range(0, 7) == 0) ?
                      CSR_DATA_W'($urandom()) : CSR_DATA_W'($urandom_range(1, 8)));
            case ($urandom_range(0, 9))
               0: write_reg(CSR_COL_COUNT, CSR_DATA_W'($urandom()));
               1: write_reg(CSR_COL_COUNT, 10'd64);
               default: write_reg(CSR_COL_COUNT, CSR_DATA_W'($urandom_range(1, 8)));
            endcase
         end
         n = cur_rows * cur_cols;
         if (n > 12) n = 12;
         n += $urandom_range(0, 3);
         repeat (n) begin
            if (rows_ready() && $urandom_range(0, 4) == 0)
               pick_request();
            else
               send_load();
            random_items++;
         end
         repeat ($urandom_range(1, 3)) begin
            if (rows_ready()) pick_request();
            random_items++;
         end
         settle();
      end

      settle();
      $display("covered %0d element loads and %0d distance requests (%0d out of range)",
               loads_sent, requests_sent, ignored_sent);
      $display("checked %0d result beats over column counts 1 to 64 and row counts 1 to 32",
               beats_checked);
      if (failure_count == 0 && pending_count == 0)
         $display("PASS jaccard_distance_matrix");
      else
         $display("FAIL jaccard_distance_matrix");
      $finish;
   end

endmodule
